// ----- sv/tpi2c_pkg.sv -----
// Package: operation codes, register map constants and the map read function.
`default_nettype none

package tpi2c_pkg;

  localparam int OP_W = 3;
  localparam int ADDR_W = 16;
  localparam int COORD_W = 16;
  localparam int HOLD_W = 16;
  localparam int SEEN_W = 2;

  localparam logic [OP_W-1:0] OP_START_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_START_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_BYTE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_BYTE   = 3'd3;
  localparam logic [OP_W-1:0] OP_TOUCH       = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK        = 3'd5;

  localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
  localparam logic [SEEN_W-1:0] SEEN_HIGH = 2'd1;
  localparam logic [SEEN_W-1:0] SEEN_BOTH = 2'd2;

  localparam logic [ADDR_W-1:0] ID_BASE     = 16'h8140;
  localparam logic [ADDR_W-1:0] STATUS_ADDR = 16'h814E;
  localparam logic [ADDR_W-1:0] POINT_BASE  = 16'h8150;

  localparam logic [7:0] STATUS_TOUCH = 8'h81;
  localparam logic [7:0] STATUS_IDLE  = 8'h80;
  localparam logic [7:0] CONTACT_SIZE = 8'd20;
  localparam logic [7:0] ID_BYTE0     = 8'h39;
  localparam logic [7:0] ID_BYTE1     = 8'h31;
  localparam logic [7:0] ID_BYTE2     = 8'h31;
  localparam logic [7:0] ID_BYTE3     = 8'h00;

  localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd150;

  typedef struct packed {
    logic               touching;
    logic               pending;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } touch_state_t;

  function automatic logic [7:0] map_read(input logic [ADDR_W-1:0] addr,
                                          input touch_state_t ts);
    logic [7:0] data;
    data = 8'd0;
    unique case (addr)
      ID_BASE:                    data = ID_BYTE0;
      ID_BASE + 16'd1:            data = ID_BYTE1;
      ID_BASE + 16'd2:            data = ID_BYTE2;
      ID_BASE + 16'd3:            data = ID_BYTE3;
      STATUS_ADDR:                data = ts.touching ? STATUS_TOUCH : STATUS_IDLE;
      POINT_BASE:                 data = ts.x[7:0];
      POINT_BASE + 16'd1:         data = ts.x[15:8];
      POINT_BASE + 16'd2:         data = ts.y[7:0];
      POINT_BASE + 16'd3:         data = ts.y[15:8];
      POINT_BASE + 16'd4:         data = ts.touching ? CONTACT_SIZE : 8'd0;
      default:                    data = 8'd0;
    endcase
    return data;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tpi2c_ifs.sv -----
// Interfaces: input item channel and result item channel.
`default_nettype none

interface tpi2c_in_if;
  logic                         valid;
  logic                         ready;
  logic [tpi2c_pkg::OP_W-1:0]   operation;
  logic [7:0]                   write_byte;
  logic [tpi2c_pkg::COORD_W-1:0] touch_x;
  logic [tpi2c_pkg::COORD_W-1:0] touch_y;
  logic                         finger_down;

  modport source (output valid, operation, write_byte, touch_x, touch_y, finger_down,
                  input ready);
  modport sink (input valid, operation, write_byte, touch_x, touch_y, finger_down,
                output ready);
endinterface

interface tpi2c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       contact;
  logic       release_waiting;

  modport source (output valid, read_data, contact, release_waiting, input ready);
  modport sink (input valid, read_data, contact, release_waiting, output ready);
endinterface

`default_nettype wire

// ----- sv/tpi2c_touch.sv -----
// Touch contact tracker: point, hold countdown and deferred release.
`default_nettype none

module tpi2c_touch (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [tpi2c_pkg::OP_W-1:0]    operation,
  input  wire logic [tpi2c_pkg::COORD_W-1:0] touch_x,
  input  wire logic [tpi2c_pkg::COORD_W-1:0] touch_y,
  input  wire logic                          finger_down,
  input  wire logic [tpi2c_pkg::HOLD_W-1:0]  hold_ticks,
  output tpi2c_pkg::touch_state_t            state,
  output tpi2c_pkg::touch_state_t            state_next
);

  tpi2c_pkg::touch_state_t             cur;
  logic [tpi2c_pkg::HOLD_W-1:0]        hold_remaining;
  logic [tpi2c_pkg::HOLD_W-1:0]        hold_remaining_next;
  logic [tpi2c_pkg::COORD_W-1:0]       pending_x;
  logic [tpi2c_pkg::COORD_W-1:0]       pending_y;
  logic [tpi2c_pkg::COORD_W-1:0]       pending_x_next;
  logic [tpi2c_pkg::COORD_W-1:0]       pending_y_next;
  logic [tpi2c_pkg::HOLD_W-1:0]        hold_dec;

  assign hold_dec = (hold_remaining != '0) ? hold_remaining - 1'b1 : hold_remaining;

  always_comb begin
    state_next          = cur;
    hold_remaining_next = hold_remaining;
    pending_x_next      = pending_x;
    pending_y_next      = pending_y;
    if (operation == tpi2c_pkg::OP_TOUCH) begin
      if (finger_down) begin
        if (!cur.touching || cur.pending) begin
          hold_remaining_next = hold_ticks;
        end
        state_next.touching = 1'b1;
        state_next.pending  = 1'b0;
        state_next.x        = touch_x;
        state_next.y        = touch_y;
      end else if (cur.touching && hold_remaining != '0) begin
        state_next.pending = 1'b1;
        pending_x_next     = touch_x;
        pending_y_next     = touch_y;
      end else begin
        state_next.touching = 1'b0;
        state_next.pending  = 1'b0;
        state_next.x        = touch_x;
        state_next.y        = touch_y;
      end
    end else if (operation == tpi2c_pkg::OP_TICK) begin
      hold_remaining_next = hold_dec;
      if (hold_dec == '0 && cur.pending) begin
        state_next.touching = 1'b0;
        state_next.pending  = 1'b0;
        state_next.x        = pending_x;
        state_next.y        = pending_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur            <= '0;
      hold_remaining <= '0;
      pending_x      <= '0;
      pending_y      <= '0;
    end else if (step) begin
      cur            <= state_next;
      hold_remaining <= hold_remaining_next;
      pending_x      <= pending_x_next;
      pending_y      <= pending_y_next;
    end
  end

  assign state = cur;

endmodule

`default_nettype wire

// ----- sv/touch_panel_i2c_register_file_unit.sv -----
// Top level: touch controller register file behind a bus-byte item channel.
//
// Items arrive on the item channel (valid/ready). Each carries one bus event:
// start of a write, start of a read, a written byte, a read byte, a touch
// report or a time tick. Every accepted item yields exactly one result item on
// the result channel: the register byte for a read, zero otherwise, plus the
// contact state and the deferred-release flag after the item.
// A result is valid in the cycle after its item is accepted. Throughput is one
// item per cycle while the receiver keeps up; the single result register is
// the only stage, and the block takes a new item whenever that register is
// empty or is being emptied in the same cycle.
// When the receiver stalls, the result holds and ready drops until it is taken.
// hold_ticks is written through cfg_we/cfg_wdata and resets to 150.
// Synchronous reset clears the address, offset, contact, hold countdown,
// pending release and the result valid flag.
`default_nettype none

module touch_panel_i2c_register_file_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tpi2c_pkg::HOLD_W-1:0] cfg_wdata,
  tpi2c_in_if.sink                          item,
  tpi2c_out_if.source                       result
);

  logic [tpi2c_pkg::HOLD_W-1:0] hold_ticks;
  logic [tpi2c_pkg::ADDR_W-1:0] reg_address;
  logic [tpi2c_pkg::ADDR_W-1:0] reg_address_next;
  logic [tpi2c_pkg::SEEN_W-1:0] address_bytes_seen;
  logic [tpi2c_pkg::SEEN_W-1:0] address_bytes_seen_next;
  logic [tpi2c_pkg::ADDR_W-1:0] read_offset;
  logic [tpi2c_pkg::ADDR_W-1:0] read_offset_next;
  logic [7:0]                   data_next;
  logic                         out_valid;
  logic [7:0]                   out_data;
  logic                         out_contact;
  logic                         out_pending;
  logic                         step;

  tpi2c_pkg::touch_state_t touch_state;
  tpi2c_pkg::touch_state_t touch_state_next;

  assign item.ready = !out_valid || result.ready;
  assign step       = item.valid && item.ready;

  tpi2c_touch u_touch (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .operation   (item.operation),
    .touch_x     (item.touch_x),
    .touch_y     (item.touch_y),
    .finger_down (item.finger_down),
    .hold_ticks  (hold_ticks),
    .state       (touch_state),
    .state_next  (touch_state_next)
  );

  always_comb begin
    reg_address_next        = reg_address;
    address_bytes_seen_next = address_bytes_seen;
    read_offset_next        = read_offset;
    data_next               = 8'd0;
    unique case (item.operation)
      tpi2c_pkg::OP_START_WRITE: address_bytes_seen_next = tpi2c_pkg::SEEN_NONE;
      tpi2c_pkg::OP_START_READ:  read_offset_next = '0;
      tpi2c_pkg::OP_WRITE_BYTE: begin
        if (address_bytes_seen == tpi2c_pkg::SEEN_NONE) begin
          reg_address_next        = {item.write_byte, 8'd0};
          address_bytes_seen_next = tpi2c_pkg::SEEN_HIGH;
        end else if (address_bytes_seen == tpi2c_pkg::SEEN_HIGH) begin
          reg_address_next        = {reg_address[15:8], item.write_byte};
          address_bytes_seen_next = tpi2c_pkg::SEEN_BOTH;
          read_offset_next        = '0;
        end
      end
      tpi2c_pkg::OP_READ_BYTE: begin
        data_next        = tpi2c_pkg::map_read(reg_address + read_offset, touch_state);
        read_offset_next = read_offset + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= tpi2c_pkg::HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_address        <= '0;
      address_bytes_seen <= tpi2c_pkg::SEEN_NONE;
      read_offset        <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (step) begin
        reg_address        <= reg_address_next;
        address_bytes_seen <= address_bytes_seen_next;
        read_offset        <= read_offset_next;
        out_valid          <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data    <= data_next;
      out_contact <= touch_state_next.touching;
      out_pending <= touch_state_next.pending;
    end
  end

  assign result.valid           = out_valid;
  assign result.read_data       = out_data;
  assign result.contact         = out_contact;
  assign result.release_waiting = out_pending;

endmodule

`default_nettype wire

// ----- sv/tpi2c_checker.sv -----
// Checker: port-level assertions for the touch register file, with its bind.
`default_nettype none

module tpi2c_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [tpi2c_pkg::OP_W-1:0] in_operation,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [7:0]                 out_read_data,
  input wire logic                       out_contact,
  input wire logic                       out_release_waiting
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_pending_touching: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_release_waiting |-> out_contact)
    else $error("release pending without contact");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_operation != tpi2c_pkg::OP_READ_BYTE
      |=> out_read_data == 8'd0)
    else $error("nonzero data on non-read item");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

endmodule

bind touch_panel_i2c_register_file_unit tpi2c_checker u_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (item.valid),
  .in_ready            (item.ready),
  .in_operation        (item.operation),
  .out_valid           (result.valid),
  .out_ready           (result.ready),
  .out_read_data       (result.read_data),
  .out_contact         (result.contact),
  .out_release_waiting (result.release_waiting)
);

`default_nettype wire

// ----- sim/touch_panel_i2c_register_file_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench: random and directed bus/touch items checked against a built-in touch register model.
module touch_panel_i2c_register_file_unit_tb;
  import tpi2c_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int BACKLOG_CYCLES = 64;
  localparam int SWEEP_READS = 24;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [7:0] read_data;
    logic       contact;
    logic       release_waiting;
  } touch_result_t;

  class touch_regfile_scoreboard;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [ADDR_W-1:0]  reg_addr;
    logic [SEEN_W-1:0]  addr_seen;
    logic [ADDR_W-1:0]  rd_offset;
    logic               touching;
    logic               lift_deferred;
    logic [COORD_W-1:0] cur_x, cur_y, pend_x, pend_y;
    logic [HOLD_W-1:0]  hold_left;
    touch_result_t      expected_q[$];
    int errors, checked, reads, releases_landed, releases_cancelled;

    function new();
      hold_ticks = HOLD_TICKS_RESET;
      reg_addr = '0;
      addr_seen = SEEN_NONE;
      rd_offset = '0;
      touching = 1'b0;
      lift_deferred = 1'b0;
      cur_x = '0;
      cur_y = '0;
      pend_x = '0;
      pend_y = '0;
      hold_left = '0;
      errors = 0;
      checked = 0;
      reads = 0;
      releases_landed = 0;
      releases_cancelled = 0;
    endfunction

    function logic [7:0] register_byte(input logic [ADDR_W-1:0] a);
      logic [7:0] ident [4];
      logic [7:0] data;
      ident = '{8'h39, 8'h31, 8'h31, 8'h00};
      data = 8'h00;
      if (a >= ID_BASE && a <= ID_BASE + 16'd3) begin
        data = ident[a - ID_BASE];
      end else begin
        case (a)
          STATUS_ADDR:        data = touching ? 8'h81 : 8'h80;
          POINT_BASE:         data = cur_x[7:0];
          POINT_BASE + 16'd1: data = cur_x[15:8];
          POINT_BASE + 16'd2: data = cur_y[7:0];
          POINT_BASE + 16'd3: data = cur_y[15:8];
          POINT_BASE + 16'd4: data = touching ? 8'd20 : 8'd0;
          default:            data = 8'h00;
        endcase
      end
      return data;
    endfunction

    function void note_item(input logic [OP_W-1:0] op, input logic [7:0] wb,
                            input logic [COORD_W-1:0] x, y, input logic fd);
      touch_result_t r;
      r = '0;
      case (op)
        OP_START_WRITE: addr_seen = SEEN_NONE;
        OP_START_READ:  rd_offset = '0;
        OP_WRITE_BYTE: begin
          if (addr_seen == SEEN_NONE) begin
            reg_addr = {wb, 8'h00};
            addr_seen = SEEN_HIGH;
          end else if (addr_seen == SEEN_HIGH) begin
            reg_addr[7:0] = wb;
            addr_seen = SEEN_BOTH;
            rd_offset = '0;
          end
        end
        OP_READ_BYTE: begin
          r.read_data = register_byte(reg_addr + rd_offset);
          rd_offset++;
          reads++;
        end
        OP_TOUCH: begin
          if (fd) begin
            if (lift_deferred) begin
              lift_deferred = 1'b0;
              touching = 1'b0;
              releases_cancelled++;
            end
            if (!touching) hold_left = hold_ticks;
            touching = 1'b1;
            cur_x = x;
            cur_y = y;
          end else if (touching && hold_left != 0) begin
            lift_deferred = 1'b1;
            pend_x = x;
            pend_y = y;
          end else begin
            lift_deferred = 1'b0;
            touching = 1'b0;
            cur_x = x;
            cur_y = y;
          end
        end
        OP_TICK: begin
          if (hold_left != 0) hold_left--;
          if (hold_left == 0 && lift_deferred) begin
            lift_deferred = 1'b0;
            touching = 1'b0;
            cur_x = pend_x;
            cur_y = pend_y;
            releases_landed++;
          end
        end
        default: ;
      endcase
      r.contact = touching;
      r.release_waiting = lift_deferred;
      expected_q.push_back(r);
    endfunction

    function void check_result(input logic [7:0] rd, input logic ct, input logic rw);
      touch_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: read_data=%02h contact=%0b release_waiting=%0b",
               rd, ct, rw);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (rd !== want.read_data) begin
        $error("read_data mismatch: expected %02h, actual %02h", want.read_data, rd);
        errors++;
      end
      if (ct !== want.contact) begin
        $error("contact mismatch: expected %0b, actual %0b", want.contact, ct);
        errors++;
      end
      if (rw !== want.release_waiting) begin
        $error("release_waiting mismatch: expected %0b, actual %0b", want.release_waiting, rw);
        errors++;
      end
    endfunction

    function void check_leftovers();
      if (expected_q.size() != 0) begin
        $error("%0d expected result items never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [HOLD_W-1:0] cfg_wdata = '0;

  tpi2c_in_if  item_ch ();
  tpi2c_out_if result_ch ();

  touch_panel_i2c_register_file_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  touch_regfile_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int items_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int next_backlog = 300;
  int backlogs = 0;

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic int tick_run();
    if (sb.hold_ticks <= 16) return $urandom_range(0, sb.hold_ticks + 1);
    if (sb.hold_ticks <= 200 && $urandom_range(0, 7) == 0) return sb.hold_ticks + 2;
    return $urandom_range(0, 4);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] wb,
                           input logic [COORD_W-1:0] x, y, input logic fd);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.operation = op;
    item_ch.write_byte = wb;
    item_ch.touch_x = x;
    item_ch.touch_y = y;
    item_ch.finger_down = fd;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(op, wb, x, y, fd);
    items_sent++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    send_item(op, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_WRITE_BYTE, b, 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic send_touch(input logic [COORD_W-1:0] x, y, input logic fd);
    send_item(OP_TOUCH, 8'($urandom), x, y, fd);
  endtask

  task automatic load_address(input logic [ADDR_W-1:0] a);
    send_op(OP_START_WRITE);
    send_byte(a[15:8]);
    send_byte(a[7:0]);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] v);
    drain_and_settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.hold_ticks = v;
  endtask

  task automatic random_burst(input int n);
    int stop_at, pick;
    logic [ADDR_W-1:0] a;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        if ($urandom_range(0, 9) < 7) a = ID_BASE - 16'd2 + 16'($urandom_range(0, 24));
        else if ($urandom_range(0, 1) == 0) a = 16'hFFF8 + 16'($urandom_range(0, 7));
        else a = 16'($urandom);
        if ($urandom_range(0, 9) != 0) begin
          load_address(a);
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
        end else begin
          send_op(OP_START_WRITE);
          send_byte(a[15:8]);
        end
        if ($urandom_range(0, 7) != 0) send_op(OP_START_READ);
        repeat ($urandom_range(1, 7)) send_op(OP_READ_BYTE);
      end else if (pick < 67) begin
        send_touch(16'($urandom), 16'($urandom), 1'b1);
        repeat ($urandom_range(0, 3)) send_touch(16'($urandom), 16'($urandom), 1'b1);
        repeat (tick_run()) send_op(OP_TICK);
        send_touch(16'($urandom), 16'($urandom), 1'b0);
        if ($urandom_range(0, 3) == 0) send_touch(16'($urandom), 16'($urandom), 1'b1);
        repeat (tick_run()) send_op(OP_TICK);
      end else if (pick < 85) begin
        repeat (tick_run()) send_op(OP_TICK);
      end else begin
        send_item(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom));
      end
    end
  endtask

  task automatic directed_part();
    load_address(ID_BASE);
    send_byte(8'hFF);
    send_op(OP_START_READ);
    repeat (4) send_op(OP_READ_BYTE);
    send_touch(16'hFFFF, 16'hFFFF, 1'b1);
    send_touch(16'h0000, 16'h0000, 1'b0);
    send_touch(16'h0000, 16'hFFFF, 1'b1);
    send_touch(16'h1234, 16'hABCD, 1'b0);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_touch(16'hFFFF, 16'h0000, 1'b0);
    load_address(16'hFFFF);
    send_op(OP_READ_BYTE);
    send_op(OP_READ_BYTE);
    send_op(OP_SPARE_6);
    send_op(OP_SPARE_7);
  endtask

  initial begin
    int stall;
    result_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (results_seen >= next_backlog) begin
        stall = BACKLOG_CYCLES;
        next_backlog += 500;
        backlogs++;
      end
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        stall--;
      end else begin
        result_ch.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result(result_ch.read_data, result_ch.contact, result_ch.release_waiting);
      results_seen++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("touch_panel_i2c_register_file_unit test failed");
    $finish;
  end

  initial begin
    logic [HOLD_W-1:0] mid_hold;
    item_ch.valid = 1'b0;
    item_ch.operation = OP_START_WRITE;
    item_ch.write_byte = '0;
    item_ch.touch_x = '0;
    item_ch.touch_y = '0;
    item_ch.finger_down = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    random_burst(120);
    write_hold(16'd2);
    directed_part();
    write_hold(16'd1);
    random_burst(150);
    write_hold(16'd0);
    random_burst(120);
    write_hold(16'hFFFF);
    random_burst(120);
    mid_hold = 16'($urandom_range(3, 12));
    write_hold(mid_hold);
    gaps_on = 1'b0;
    random_burst(150);
    gaps_on = 1'b1;
    write_hold(HOLD_TICKS_RESET);
    random_burst(150);

    gaps_on = 1'b0;
    load_address(ID_BASE);
    send_op(OP_START_READ);
    repeat (SWEEP_READS) send_op(OP_READ_BYTE);
    gaps_on = 1'b1;

    drain_and_settle();
    sb.check_leftovers();
    $display("%0d items, %0d results checked, %0d register reads, %0d receiver backlogs",
             items_sent, sb.checked, sb.reads, backlogs);
    $display("hold 150/2/1/0/65535/%0d: %0d deferred releases landed, %0d cancelled by presses",
             mid_hold, sb.releases_landed, sb.releases_cancelled);
    if (sb.errors == 0) begin
      $display("touch_panel_i2c_register_file_unit test passed");
    end else begin
      $display("touch_panel_i2c_register_file_unit test failed");
    end
    $finish;
  end

endmodule
